// ----- hdl/hbrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrd_pkg
// Shared types and constants of the heart beat rate detector: register
// indexes, reset values, sequencer states and the history control bundle.
// ----------------------------------------------------------------------------
package hbrd_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_SAMPLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_MS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BPM_LOW_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BPM_HIGH_LIMIT = 3'd5;

	// Field widths
	localparam int MS_W       = 8;
	localparam int RATE_W     = 8;
	localparam int INTERVAL_W = 16;
	localparam int CLOCK_W    = 32;

	// Register reset values
	localparam logic [MS_W-1:0]       MS_PER_SAMPLE_RESET  = 8'd2;
	localparam int                    LEVEL_RESET          = 512;
	localparam logic [INTERVAL_W-1:0] REFRACTORY_RESET     = 16'd250;
	localparam logic [INTERVAL_W-1:0] TIMEOUT_RESET        = 16'd2500;
	localparam logic [RATE_W-1:0]     BPM_LOW_RESET        = 8'd30;
	localparam logic [RATE_W-1:0]     BPM_HIGH_RESET       = 8'd200;

	// Interval and rate constants
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 16'd600;
	localparam logic [INTERVAL_W-1:0] INTERVAL_MAX    = 16'hFFFF;
	localparam int                    RATE_DIVIDEND   = 60000;

	// Interval / 5 by reciprocal: floor(x * 52429 / 2^18), exact for 16-bit x
	localparam logic [INTERVAL_W-1:0] DIV5_MUL   = 16'd52429;
	localparam int                    DIV5_SHIFT = 18;
	localparam int                    FIFTH_W    = 14;
	localparam logic [FIFTH_W-1:0]    FIFTH_RESET = 14'd120;
	localparam logic [INTERVAL_W-1:0] GUARD_RESET = 16'd360;

	// Sample sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_RATE_GO,
		ST_RATE_WAIT,
		ST_FINISH
	} hbrd_state_t;

	// History shift line control
	typedef struct packed {
		logic                  shift;
		logic                  fill;
		logic [INTERVAL_W-1:0] interval;
	} hist_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/hbrd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrd_if
// Valid/ready channels of the detector: sample input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface hbrd_sample_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface hbrd_result_if
	import hbrd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
);
	logic                   valid;
	logic                   ready;
	logic [RATE_W-1:0]      bpm;
	logic                   beat_found;
	logic                   pulse_high;
	logic [SAMPLE_BITS-1:0] threshold;
	logic [INTERVAL_W-1:0]  interval_ms;

	modport source (output valid, output bpm, output beat_found, output pulse_high,
		output threshold, output interval_ms, input ready);
	modport sink   (input valid, input bpm, input beat_found, input pulse_high,
		input threshold, input interval_ms, output ready);
endinterface

interface hbrd_cfg_if
	import hbrd_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/hbrd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrd_div
// Bit-serial restoring divider: one quotient bit per cycle until all NUM_W
// quotient bits are in. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module hbrd_div
	import hbrd_pkg::*;
#(
	parameter int NUM_W = 20,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             borrow;

	// Trial subtract of the next partial remainder
	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign borrow = diff[DEN_W+1];

	assign busy = (cnt_q != '0);
	assign quot = num_q;

	// Count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Shift the dividend out and the quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[NUM_W-2:0], ~borrow};
			rem_q <= borrow ? rem_sh[DEN_W-1:0] : diff[DEN_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hbrd_hist.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrd_hist
// Interval history shift line with a running sum of its entries.
// ----------------------------------------------------------------------------
module hbrd_hist
	import hbrd_pkg::*;
#(
	parameter int DEPTH = 10,
	parameter int SUM_W = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hist_ctrl_t       ctrl,
	output logic [SUM_W-1:0] sum_total
);

	logic [INTERVAL_W-1:0] hist_q [DEPTH];
	logic [SUM_W-1:0]      sum_q;

	assign sum_total = sum_q;

	// Shift in the newest interval, or fill every entry with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (ctrl.shift) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				hist_q[i] <= ctrl.fill ? ctrl.interval : hist_q[i+1];
			end
			hist_q[DEPTH-1] <= ctrl.interval;
			if (ctrl.fill) begin
				sum_q <= SUM_W'(ctrl.interval) * SUM_W'(DEPTH);
			end else begin
				sum_q <= sum_q - SUM_W'(hist_q[0]) + SUM_W'(ctrl.interval);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/heart_beat_rate_detector_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heart_beat_rate_detector_top
// Pulse beat detector with adaptive threshold and beats-per-minute output.
// ----------------------------------------------------------------------------
// One result beat per sample beat. A sample that does not complete a rate
// measurement is accepted, evaluated and loaded into the output register.
// For a sample that completes one, the bit-serial divider runs twice before
// the output load, first for the history average and then for 60000 /
// average, one quotient bit per cycle, over SUM_W = 16 + clog2(HISTORY_DEPTH)
// quotient bits. The block takes one sample at a time; the output register
// lets the next sample in while a result still waits. Configuration writes
// are always taken and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module heart_beat_rate_detector_top
	import hbrd_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10,
	parameter int SAMPLE_BITS   = 12
) (
	input  logic   clk,
	input  logic   arst_n,
	hbrd_sample_if.sink   samp,
	hbrd_result_if.source res,
	hbrd_cfg_if.sink      cfg
);

	localparam int SUM_W = INTERVAL_W + $clog2(HISTORY_DEPTH);

	// Configuration registers
	logic [MS_W-1:0]        ms_q;
	logic [SAMPLE_BITS-1:0] base_q;
	logic [INTERVAL_W-1:0]  refr_q;
	logic [INTERVAL_W-1:0]  tmo_q;
	logic [RATE_W-1:0]      lo_q;
	logic [RATE_W-1:0]      hi_q;

	// Detection state
	hbrd_state_t            state_q, state_d;
	logic [SAMPLE_BITS-1:0] s_q;
	logic [CLOCK_W-1:0]     clock_q;
	logic [CLOCK_W-1:0]     last_q;
	logic [INTERVAL_W-1:0]  iv_q;
	logic [FIFTH_W-1:0]     fifth_q;
	logic [INTERVAL_W-1:0]  guard_q;
	logic [RATE_W-1:0]      rate_q;
	logic [INTERVAL_W-1:0]  avg_q;
	logic                   pulse_q;
	logic                   first_q;
	logic                   second_q;
	logic                   found_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [SAMPLE_BITS-1:0] trough_q;
	logic [SAMPLE_BITS-1:0] thr_q;

	// Output register
	logic                   res_valid_q;
	logic [RATE_W-1:0]      bpm_q;
	logic                   beat_found_q;
	logic                   pulse_high_q;
	logic [SAMPLE_BITS-1:0] threshold_q;
	logic [INTERVAL_W-1:0]  interval_q;

	// Evaluation terms
	logic                   in_acc;
	logic                   eval_en;
	logic [CLOCK_W-1:0]     elapsed;
	logic                   el_hi;
	logic                   gt_refr;
	logic                   gt_tmo;
	logic                   gt_guard;
	logic                   above;
	logic                   below;
	logic                   beat;
	logic                   first_beat;
	logic                   rate_beat;
	logic                   falling;
	logic                   timeout;
	logic [INTERVAL_W-1:0]  iv_new;
	logic [SAMPLE_BITS-1:0] peak_n;
	logic [SAMPLE_BITS-1:0] trough_n;
	logic [SAMPLE_BITS-1:0] amp;
	logic [SAMPLE_BITS-1:0] thr_f;
	logic [CLOCK_W-1:0]     prod5;

	// Sequencer outputs
	logic                   samp_ready;
	logic                   div_start;
	logic                   avg_done;
	logic                   rate_done;
	logic                   out_load;
	logic [SUM_W-1:0]       div_num;
	logic [INTERVAL_W-1:0]  div_den;

	// Units
	hist_ctrl_t             hist_ctrl;
	logic [SUM_W-1:0]       sum_total;
	logic                   div_busy;
	logic [SUM_W-1:0]       div_quot;
	logic [RATE_W-1:0]      rate_hi;
	logic [RATE_W-1:0]      rate_clamped;

	// Handshakes
	assign in_acc          = samp.valid && samp_ready;
	assign samp.ready      = samp_ready;
	assign cfg.ready       = 1'b1;
	assign res.valid       = res_valid_q;
	assign res.bpm         = bpm_q;
	assign res.beat_found  = beat_found_q;
	assign res.pulse_high  = pulse_high_q;
	assign res.threshold   = threshold_q;
	assign res.interval_ms = interval_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q   <= MS_PER_SAMPLE_RESET;
			base_q <= SAMPLE_BITS'(LEVEL_RESET);
			refr_q <= REFRACTORY_RESET;
			tmo_q  <= TIMEOUT_RESET;
			lo_q   <= BPM_LOW_RESET;
			hi_q   <= BPM_HIGH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_MS_PER_SAMPLE:  ms_q   <= cfg.data[MS_W-1:0];
				CFG_BASELINE_LEVEL: base_q <= cfg.data[SAMPLE_BITS-1:0];
				CFG_REFRACTORY_MS:  refr_q <= cfg.data[INTERVAL_W-1:0];
				CFG_TIMEOUT_MS:     tmo_q  <= cfg.data[INTERVAL_W-1:0];
				CFG_BPM_LOW_LIMIT:  lo_q   <= cfg.data[RATE_W-1:0];
				CFG_BPM_HIGH_LIMIT: hi_q   <= cfg.data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Elapsed time since the last beat and its comparisons
	assign elapsed  = clock_q - last_q;
	assign el_hi    = |elapsed[CLOCK_W-1:INTERVAL_W];
	assign gt_refr  = el_hi || (elapsed[INTERVAL_W-1:0] > refr_q);
	assign gt_tmo   = el_hi || (elapsed[INTERVAL_W-1:0] > tmo_q);
	assign gt_guard = el_hi || (elapsed[INTERVAL_W-1:0] > guard_q);
	assign iv_new   = el_hi ? INTERVAL_MAX : elapsed[INTERVAL_W-1:0];

	// Beat qualification
	assign above      = s_q > thr_q;
	assign below      = s_q < thr_q;
	assign beat       = gt_refr && above && !pulse_q && gt_guard;
	assign first_beat = beat && first_q;
	assign rate_beat  = beat && !first_q;
	assign falling    = below && pulse_q;
	assign timeout    = gt_tmo && !first_beat;

	// Track peak and trough, then the falling-edge threshold
	assign peak_n   = (above && (s_q > peak_q)) ? s_q : peak_q;
	assign trough_n = (below && gt_guard && (s_q < trough_q)) ? s_q : trough_q;
	assign amp      = (peak_n >= trough_n) ? (peak_n - trough_n) : '0;
	assign thr_f    = trough_n + (amp >> 1);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_acc) state_d = ST_EVAL;
			ST_EVAL:      state_d = rate_beat ? ST_AVG_GO : ST_FINISH;
			ST_AVG_GO:    state_d = ST_AVG_WAIT;
			ST_AVG_WAIT:  if (!div_busy) state_d = ST_RATE_GO;
			ST_RATE_GO:   state_d = ST_RATE_WAIT;
			ST_RATE_WAIT: if (!div_busy) state_d = ST_FINISH;
			ST_FINISH:    if (!res_valid_q || res.ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		samp_ready = 1'b0;
		eval_en    = 1'b0;
		div_start  = 1'b0;
		avg_done   = 1'b0;
		rate_done  = 1'b0;
		out_load   = 1'b0;
		div_num    = SUM_W'(RATE_DIVIDEND);
		div_den    = avg_q;
		unique case (state_q)
			ST_IDLE:      samp_ready = 1'b1;
			ST_EVAL:      eval_en = 1'b1;
			ST_AVG_GO: begin
				div_start = 1'b1;
				div_num   = sum_total;
				div_den   = INTERVAL_W'(HISTORY_DEPTH);
			end
			ST_AVG_WAIT:  avg_done = !div_busy;
			ST_RATE_GO:   div_start = 1'b1;
			ST_RATE_WAIT: rate_done = !div_busy;
			ST_FINISH:    out_load = !res_valid_q || res.ready;
			default: ;
		endcase
	end

	// Latch the sample and advance the millisecond clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
		end else if (in_acc) begin
			clock_q <= clock_q + CLOCK_W'(ms_q);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q <= samp.sample;
		end
	end

	// Apply beat, falling edge and timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			iv_q     <= INTERVAL_RESET;
			pulse_q  <= 1'b0;
			first_q  <= 1'b1;
			second_q <= 1'b0;
			found_q  <= 1'b0;
			peak_q   <= SAMPLE_BITS'(LEVEL_RESET);
			trough_q <= SAMPLE_BITS'(LEVEL_RESET);
			thr_q    <= SAMPLE_BITS'(LEVEL_RESET);
		end else if (eval_en) begin
			found_q <= rate_beat;
			if (beat) begin
				pulse_q <= 1'b1;
				iv_q    <= iv_new;
			end else if (falling) begin
				pulse_q <= 1'b0;
			end
			if (beat || timeout) begin
				last_q <= clock_q;
			end
			if (timeout) begin
				first_q  <= 1'b1;
				second_q <= 1'b0;
			end else if (first_beat) begin
				first_q  <= 1'b0;
				second_q <= 1'b1;
			end else if (rate_beat) begin
				second_q <= 1'b0;
			end
			if (timeout) begin
				thr_q    <= base_q;
				peak_q   <= base_q;
				trough_q <= base_q;
			end else if (falling) begin
				thr_q    <= thr_f;
				peak_q   <= thr_f;
				trough_q <= thr_f;
			end else begin
				peak_q   <= peak_n;
				trough_q <= trough_n;
			end
		end
	end

	// Guard time: three fifths of the last interval, registered in fifth_q, then guard_q
	assign prod5 = CLOCK_W'(iv_q) * CLOCK_W'(DIV5_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifth_q <= FIFTH_RESET;
			guard_q <= GUARD_RESET;
		end else begin
			fifth_q <= prod5[DIV5_SHIFT +: FIFTH_W];
			guard_q <= (INTERVAL_W'(fifth_q) << 1) + INTERVAL_W'(fifth_q);
		end
	end

	// Interval history
	assign hist_ctrl.shift    = eval_en && rate_beat;
	assign hist_ctrl.fill     = second_q;
	assign hist_ctrl.interval = iv_new;

	hbrd_hist #(
		.DEPTH (HISTORY_DEPTH),
		.SUM_W (SUM_W)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (hist_ctrl),
		.sum_total (sum_total)
	);

	// Shared serial divider: average, then rate
	hbrd_div #(
		.NUM_W (SUM_W),
		.DEN_W (INTERVAL_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// Clamp the rate: ceiling first, then floor
	assign rate_hi      = (div_quot > SUM_W'(hi_q)) ? hi_q : div_quot[RATE_W-1:0];
	assign rate_clamped = (rate_hi < lo_q) ? lo_q : rate_hi;

	always_ff @(posedge clk) begin
		if (avg_done) begin
			avg_q <= div_quot[INTERVAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
		end else if (rate_done) begin
			rate_q <= rate_clamped;
		end
	end

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bpm_q        <= rate_q;
			beat_found_q <= found_q;
			pulse_high_q <= pulse_q;
			threshold_q  <= thr_q;
			interval_q   <= iv_q;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/hbrd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbrd_checker
// Port-level checks of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module hbrd_checker
	import hbrd_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   samp_valid,
	input wire logic                   samp_ready,
	input wire logic                   res_valid,
	input wire logic                   res_ready,
	input wire logic [RATE_W-1:0]      bpm,
	input wire logic                   beat_found,
	input wire logic                   pulse_high,
	input wire logic [SAMPLE_BITS-1:0] threshold,
	input wire logic [INTERVAL_W-1:0]  interval_ms
);

	// Hold a stalled result beat
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// Keep the stalled payload stable
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(bpm) && $stable(beat_found)
			&& $stable(pulse_high) && $stable(threshold) && $stable(interval_ms))
		else $error("result payload changed while stalled");

	// Take one sample at a time
	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		samp_valid && samp_ready |=> !samp_ready)
		else $error("sample taken while previous one in work");

	// A new rate comes from a rising crossing, so the pulse is high
	a_beat_in_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && beat_found |-> pulse_high)
		else $error("beat reported outside a pulse");

endmodule

bind heart_beat_rate_detector_top hbrd_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.samp_valid  (samp.valid),
	.samp_ready  (samp.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.bpm         (res.bpm),
	.beat_found  (res.beat_found),
	.pulse_high  (res.pulse_high),
	.threshold   (res.threshold),
	.interval_ms (res.interval_ms)
);
`default_nettype wire

// ----- tb/sv/hbrd_rate_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrd_rate_checker
// Watches the sample, result and register channels of the detector. Tracks
// the waveform state for every accepted sample, queues the reading it must
// produce, and compares every result beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module hbrd_rate_checker
	import hbrd_pkg::*;
#(
	parameter int HISTORY_DEPTH = 10,
	parameter int SAMPLE_BITS   = 12
) (
	input  logic   clk,
	input  logic   arst_n,
	hbrd_sample_if samp,
	hbrd_result_if res,
	hbrd_cfg_if    cfg,
	output int     failures,
	output int     pending,
	output int     rate_updates
);

	localparam int REPORT_LIMIT = 10;

	typedef logic [SAMPLE_BITS-1:0] level_t;

	typedef struct packed {
		logic [RATE_W-1:0]     bpm;
		logic                  beat_found;
		logic                  pulse_high;
		level_t                threshold;
		logic [INTERVAL_W-1:0] interval_ms;
	} reading_t;

	// Register copies
	logic [MS_W-1:0]       ms_step;
	level_t                baseline;
	logic [INTERVAL_W-1:0] refractory;
	logic [INTERVAL_W-1:0] silence_limit;
	logic [RATE_W-1:0]     rate_floor;
	logic [RATE_W-1:0]     rate_ceiling;

	// Waveform tracking state
	logic [CLOCK_W-1:0]    now_ms;
	logic [CLOCK_W-1:0]    last_beat_ms;
	logic [INTERVAL_W-1:0] last_interval;
	logic [RATE_W-1:0]     rate;
	logic                  inside_pulse;
	level_t                peak;
	level_t                trough;
	level_t                thresh;
	level_t                swing;
	logic                  need_first;
	logic                  need_second;
	logic [INTERVAL_W-1:0] history [HISTORY_DEPTH];

	reading_t expected_readings [$];

	// Advance the waveform state by one sample and return the reading it gives
	function automatic reading_t track_sample(input level_t s);
		logic [CLOCK_W-1:0] elapsed;
		logic [CLOCK_W-1:0] guard;
		logic [CLOCK_W-1:0] total;
		logic [CLOCK_W-1:0] avg;
		logic [CLOCK_W-1:0] quotient;
		logic               found;
		logic               arm_only;
		int                 i;
		reading_t           r;

		found    = 1'b0;
		arm_only = 1'b0;
		now_ms   = now_ms + ms_step;
		elapsed  = now_ms - last_beat_ms;
		guard    = (CLOCK_W'(last_interval) / 5) * 3;

		// Follow the trough only once the guard time has passed
		if (s < thresh && elapsed > guard && s < trough)
			trough = s;
		if (s > thresh && s > peak)
			peak = s;

		// Rising crossing outside the refractory and guard windows is a beat
		if (elapsed > refractory && s > thresh && !inside_pulse && elapsed > guard) begin
			inside_pulse  = 1'b1;
			last_interval = (elapsed > INTERVAL_MAX) ? INTERVAL_MAX : elapsed[INTERVAL_W-1:0];
			last_beat_ms  = now_ms;
			if (need_second) begin
				need_second = 1'b0;
				for (i = 0; i < HISTORY_DEPTH; i++)
					history[i] = last_interval;
			end
			if (need_first) begin
				// First beat only arms; skip falling edge and timeout
				need_first  = 1'b0;
				need_second = 1'b1;
				arm_only    = 1'b1;
			end else begin
				total = '0;
				for (i = 0; i < HISTORY_DEPTH - 1; i++) begin
					history[i] = history[i+1];
					total      = total + history[i];
				end
				history[HISTORY_DEPTH-1] = last_interval;
				total    = total + last_interval;
				avg      = total / HISTORY_DEPTH;
				quotient = (avg == '0) ? '1 : CLOCK_W'(RATE_DIVIDEND) / avg;
				// Ceiling first, floor last: crossed limits give the floor
				if (quotient > rate_ceiling)
					quotient = CLOCK_W'(rate_ceiling);
				if (quotient < rate_floor)
					quotient = CLOCK_W'(rate_floor);
				rate  = quotient[RATE_W-1:0];
				found = 1'b1;
			end
		end

		if (!arm_only) begin
			// Falling edge: move the threshold to the middle of the swing
			if (s < thresh && inside_pulse) begin
				inside_pulse = 1'b0;
				swing        = (peak >= trough) ? level_t'(peak - trough) : '0;
				thresh       = level_t'(swing / 2 + trough);
				peak         = thresh;
				trough       = thresh;
			end
			// Timeout restarts detection from the baseline
			if (elapsed > silence_limit) begin
				thresh       = baseline;
				peak         = baseline;
				trough       = baseline;
				last_beat_ms = now_ms;
				need_first   = 1'b1;
				need_second  = 1'b0;
			end
		end

		r.bpm         = rate;
		r.beat_found  = found;
		r.pulse_high  = inside_pulse;
		r.threshold   = thresh;
		r.interval_ms = last_interval;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		reading_t got;
		if (!arst_n) begin
			ms_step       = MS_PER_SAMPLE_RESET;
			baseline      = level_t'(LEVEL_RESET);
			refractory    = REFRACTORY_RESET;
			silence_limit = TIMEOUT_RESET;
			rate_floor    = BPM_LOW_RESET;
			rate_ceiling  = BPM_HIGH_RESET;
			now_ms        = '0;
			last_beat_ms  = '0;
			last_interval = INTERVAL_RESET;
			rate          = '0;
			inside_pulse  = 1'b0;
			peak          = level_t'(LEVEL_RESET);
			trough        = level_t'(LEVEL_RESET);
			thresh        = level_t'(LEVEL_RESET);
			swing         = level_t'(100);
			need_first    = 1'b1;
			need_second   = 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++)
				history[i] = '0;
			expected_readings.delete();
			failures      = 0;
			pending       = 0;
			rate_updates  = 0;
		end else begin
			// Register writes; spare indexes are ignored
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_MS_PER_SAMPLE:  ms_step       = cfg.data[MS_W-1:0];
					CFG_BASELINE_LEVEL: baseline      = cfg.data[SAMPLE_BITS-1:0];
					CFG_REFRACTORY_MS:  refractory    = cfg.data[INTERVAL_W-1:0];
					CFG_TIMEOUT_MS:     silence_limit = cfg.data[INTERVAL_W-1:0];
					CFG_BPM_LOW_LIMIT:  rate_floor    = cfg.data[RATE_W-1:0];
					CFG_BPM_HIGH_LIMIT: rate_ceiling  = cfg.data[RATE_W-1:0];
					default: ;
				endcase
			end

			// Queue the reading of each accepted sample beat
			if (samp.valid && samp.ready)
				expected_readings.push_back(track_sample(samp.sample));

			// Compare each result beat with the oldest queued reading
			if (res.valid && res.ready) begin
				got.bpm         = res.bpm;
				got.beat_found  = res.beat_found;
				got.pulse_high  = res.pulse_high;
				got.threshold   = res.threshold;
				got.interval_ms = res.interval_ms;
				if (expected_readings.size() == 0) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display("[%0t] result beat with no sample pending: bpm %0d", $time,
							got.bpm);
				end else begin
					want = expected_readings.pop_front();
					if (want.beat_found)
						rate_updates++;
					if (got !== want) begin
						failures++;
						if (failures <= REPORT_LIMIT)
							$display({"[%0t] mismatch (exp/act): bpm %0d/%0d found %0b/%0b ",
								"pulse %0b/%0b threshold %0d/%0d interval %0d/%0d"}, $time,
								want.bpm, got.bpm, want.beat_found, got.beat_found,
								want.pulse_high, got.pulse_high, want.threshold, got.threshold,
								want.interval_ms, got.interval_ms);
					end
				end
			end

			pending = expected_readings.size();
		end
	end

endmodule

// ----- tb/sv/tb_heart_beat_rate_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heart_beat_rate_detector_top
// Drives shaped pulse trains and noise into the detector under a series of
// register settings, extremes included, with random idling on both sides,
// a long output hold-off and idle drains between settings. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_heart_beat_rate_detector_top;
	import hbrd_pkg::*;

	localparam int HISTORY_DEPTH   = 10;
	localparam int SAMPLE_BITS     = 12;
	localparam int CLK_HALF_NS     = 6;
	localparam int RESET_CYCLES    = 11;
	localparam int SETTLE_CYCLES   = 60;
	localparam int IDLE_PCT        = 35;
	localparam int HOLD_OFF_AFTER  = 150;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int LEVEL_TOP       = (1 << SAMPLE_BITS) - 1;
	localparam int TROUGH_MAX      = 600;
	localparam int PEAK_MIN        = 2800;
	localparam int RANDOM_SETTINGS = 5;
	localparam int RANDOM_SAMPLES  = 40;
	localparam int SHAPED_COUNT    = 25;

	// Indexes past the register list; the block must ignore them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	// Hand-shaped waveform: arm, fill, then rate updates with odd levels
	localparam logic [SAMPLE_BITS-1:0] SHAPED_BEATS [SHAPED_COUNT] = '{
		12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095,
		12'd0, 12'd1, 12'd2048, 12'd4095, 12'd4094, 12'd0, 12'd0, 12'd0, 12'd0,
		12'd4095, 12'd0, 12'd2047, 12'd2049, 12'd0, 12'd0, 12'd4095
	};

	logic clk;
	logic arst_n;
	logic steady = 1'b0;
	int   failures;
	int   pending;
	int   rate_updates;
	int   samples_sent   = 0;
	int   results_taken  = 0;
	int   settings_used  = 0;
	int   hold_left      = 0;
	bit   long_hold_done = 1'b0;

	hbrd_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samp_ch ();
	hbrd_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_ch ();
	hbrd_cfg_if                                 cfg_ch ();

	heart_beat_rate_detector_top #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.samp  (samp_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	hbrd_rate_checker #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.samp        (samp_ch),
		.res         (res_ch),
		.cfg         (cfg_ch),
		.failures    (failures),
		.pending     (pending),
		.rate_updates(rate_updates)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: random stalls, one long hold-off, steady stretches
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				results_taken++;
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (!long_hold_done && results_taken >= HOLD_OFF_AFTER) begin
				long_hold_done = 1'b1;
				hold_left      = HOLD_OFF_CYCLES;
				res_ch.ready   <= 1'b0;
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one sample beat, with random gaps ahead of it
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			samp_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samp_ch.valid  <= 1'b1;
		samp_ch.sample <= s;
		@(posedge clk);
		while (!samp_ch.ready)
			@(posedge clk);
		samples_sent++;
	endtask

	// Hold the input until every queued reading has come out
	task automatic wait_idle();
		samp_ch.valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	// Write every register, plus one spare index, while idle
	task automatic apply_settings(input int ms_step, input int base_level, input int refr,
		input int silence, input int floor_bpm, input int ceil_bpm);
		wait_idle();
		write_reg(CFG_MS_PER_SAMPLE, CFG_DATA_W'(ms_step));
		write_reg(CFG_BASELINE_LEVEL, CFG_DATA_W'(base_level));
		write_reg(CFG_REFRACTORY_MS, CFG_DATA_W'(refr));
		write_reg(CFG_TIMEOUT_MS, CFG_DATA_W'(silence));
		write_reg(CFG_BPM_LOW_LIMIT, CFG_DATA_W'(floor_bpm));
		write_reg(CFG_BPM_HIGH_LIMIT, CFG_DATA_W'(ceil_bpm));
		write_reg(($urandom_range(1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Pulses of random period and width with random levels and some noise
	task automatic drive_pulse_train(input int n, input int period_min, input int period_max);
		int                     done;
		int                     period;
		int                     width;
		int                     k;
		logic [SAMPLE_BITS-1:0] s;
		done = 0;
		while (done < n) begin
			period = $urandom_range(period_max, period_min);
			width  = 1 + $urandom_range(period / 4);
			for (k = 0; k < period && done < n; k++) begin
				if ($urandom_range(9) == 0)
					s = SAMPLE_BITS'($urandom);
				else if (k < width)
					s = SAMPLE_BITS'($urandom_range(LEVEL_TOP, PEAK_MIN));
				else
					s = SAMPLE_BITS'($urandom_range(TROUGH_MAX, 0));
				send_sample(s);
				done++;
			end
		end
	endtask

	// Stimulus and verdict
	initial begin
		arst_n         <= 1'b0;
		samp_ch.valid  <= 1'b0;
		samp_ch.sample <= '0;
		cfg_ch.valid   <= 1'b0;
		cfg_ch.index   <= '0;
		cfg_ch.data    <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: a few samples at the floor, top and baseline
		send_sample('0);
		send_sample(SAMPLE_BITS'(LEVEL_TOP));
		send_sample(SAMPLE_BITS'(LEVEL_RESET));

		// Hand-shaped beats at a realistic setting
		apply_settings(100, 2048, 250, 2500, 30, 200);
		foreach (SHAPED_BEATS[i])
			send_sample(SHAPED_BEATS[i]);

		// Random settings; one of them runs with no idling at all
		for (int p = 0; p < RANDOM_SETTINGS; p++) begin
			steady = (p == 2);
			apply_settings($urandom_range(120, 15), $urandom_range(3000, 500),
				$urandom_range(600, 0), $urandom_range(6000, 800), $urandom_range(60, 0),
				$urandom_range(255, 120));
			drive_pulse_train(RANDOM_SAMPLES, 6, 30);
		end
		steady = 1'b0;

		// All registers at their lowest: a timeout on every sample that is not a first beat
		apply_settings(1, 0, 0, 0, 0, 0);
		drive_pulse_train(24, 2, 6);

		// All but the baseline at their highest: elapsed time passes the interval ceiling
		apply_settings(255, 0, 16'hFFFF, 16'hFFFF, 255, 255);
		drive_pulse_train(270, 6, 30);

		// Top baseline: the threshold cannot be crossed
		apply_settings(255, LEVEL_TOP, 0, 300, 200, 50);
		drive_pulse_train(20, 2, 6);

		// Crossed limits, and beats that land together with a timeout
		apply_settings(255, 1500, 0, 300, 200, 50);
		drive_pulse_train(60, 2, 4);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run: %0d samples over %0d register settings, %0d rate updates checked.",
			samples_sent, settings_used, rate_updates);
		$display("Included a %0d-cycle output hold-off and idle drains between settings.",
			HOLD_OFF_CYCLES);
		if (failures == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/hbrd_pkg.sv
hdl/hbrd_if.sv
hdl/hbrd_div.sv
hdl/hbrd_hist.sv
hdl/heart_beat_rate_detector_top.sv
hdl/hbrd_checker.sv
tb/sv/hbrd_rate_checker.sv
tb/sv/tb_heart_beat_rate_detector_top.sv
